// File: rtl/stt_pkg.sv
`default_nettype none
package stt_pkg;

  localparam int unsigned LINE_BITS   = 20;
  localparam int unsigned COL_BITS    = 16;
  localparam int unsigned OFFSET_BITS = 24;

  localparam logic REG_TAB_WIDTH = 1'b0;
  localparam logic REG_CLOSE_ADJ = 1'b1;

  typedef enum logic [2:0] {
    M_NONE,
    M_STRING,
    M_CHAR,
    M_LCOMMENT,
    M_BCOMMENT,
    M_IDENT,
    M_NUMBER
  } scan_mode_e;

  typedef enum logic [2:0] {
    T_COMMENT,
    T_CHAR,
    T_STRING,
    T_IDENT,
    T_SYMBOL,
    T_NUMBER,
    T_LINEEND,
    T_FILEEND
  } tok_type_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FLUSH,
    PH_END
  } phase_e;

  typedef struct packed {
    logic [LINE_BITS-1:0]   line;
    logic [COL_BITS-1:0]    col;
    logic [OFFSET_BITS-1:0] off;
  } pos_t;

  // one scan step: close record, up to two text bytes, one more record
  typedef struct packed {
    logic      last;
    logic      r1_valid;
    tok_type_e r1_type;
    pos_t      r1_start;
    pos_t      r1_end;
    logic      t0_valid;
    logic      t1_valid;
    tok_type_e t_type;
    logic [7:0] t0_byte;
    logic [7:0] t1_byte;
    logic      r2_valid;
    tok_type_e r2_type;
    pos_t      r2_pos;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } front_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// File: rtl/stt_queue.sv
`default_nettype none
module stt_queue
  import stt_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire front_push_t push_i,
  input  wire logic        pop_i,
  output entry_t           data_o,
  output q_stat_t          stat_o
);

  localparam int unsigned PtrBits = $clog2(DEPTH);

  entry_t             mem_q [DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrBits:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign do_push = push_i.valid && (cnt_q != DEPTH[PtrBits:0]);
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrBits'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == DEPTH[PtrBits:0]);

endmodule
`default_nettype wire

// File: rtl/stt_front.sv
`default_nettype none
module stt_front
  import stt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [3:0] tab_width_i,
  input  wire logic       close_adj_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_i,
  input  wire logic       eot_i,
  input  wire q_stat_t    q_stat_i,
  output front_push_t     push_o
);

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChUpE    = 8'h45;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2f) || (c >= 8'h3a && c <= 8'h40) ||
           (c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == ChCr) || (c == ChLf);
  endfunction

  phase_e                 phase_q, phase_d;
  scan_mode_e             mode_q, mode_d;
  tok_type_e              kind_q, kind_d;
  logic [7:0]             held_q, held_d;
  logic                   held_v_q, held_v_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COL_BITS-1:0]    col_q, col_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  pos_t                   start_q, start_d;
  logic                   any_q, any_d;
  logic                   lle_q, lle_d;

  logic accept, advance;

  assign advance    = !q_stat_i.full;
  assign in_ready_o = (phase_q == PH_IDLE) && advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (accept && eot_i) phase_d = PH_FLUSH;
      end
      PH_FLUSH: begin
        if (advance) phase_d = PH_END;
      end
      PH_END: begin
        if (advance) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    logic                   sc_en;
    logic [7:0]             c;
    logic                   hn;
    logic [7:0]             nc;
    logic [7:0]             quote;
    logic [1:0]             use_n;
    logic                   tab;
    logic                   do_close;
    logic [COL_BITS-1:0]    adv_c;
    logic [OFFSET_BITS-1:0] adv_o;
    entry_t                 e;
    pos_t                   here;

    sc_en    = 1'b0;
    c        = held_q;
    hn       = 1'b0;
    nc       = 8'h00;
    quote    = ChDquote;
    use_n    = 2'd0;
    tab      = 1'b0;
    do_close = 1'b0;
    adv_c    = '0;
    adv_o    = '0;
    e        = '0;
    here     = '{line: line_q, col: col_q, off: off_q};

    mode_d   = mode_q;
    kind_d   = kind_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    line_d   = line_q;
    col_d    = col_q;
    off_d    = off_q;
    start_d  = start_q;
    any_d    = any_q;
    lle_d    = lle_q;

    unique case (phase_q)
      PH_IDLE: begin
        sc_en = accept && held_v_q;
        hn    = 1'b1;
        nc    = char_i;
      end
      PH_FLUSH: begin
        sc_en = advance && held_v_q;
      end
      PH_END: begin
        sc_en = 1'b0;
      end
      default: sc_en = 1'b0;
    endcase

    if (sc_en) begin
      case (mode_q)
        M_STRING, M_CHAR: begin
          quote = (mode_q == M_STRING) ? ChDquote : ChSquote;
          if (c == ChBslash && hn && (nc == ChBslash || nc == quote)) begin
            e.t0_valid = 1'b1;
            e.t1_valid = 1'b1;
            use_n      = 2'd2;
          end else if (c == quote) begin
            do_close = 1'b1;
            use_n    = 2'd1;
          end else if (is_eol(c)) begin
            do_close = 1'b1;
          end else begin
            e.t0_valid = 1'b1;
            use_n      = 2'd1;
          end
        end
        M_LCOMMENT: begin
          if (is_eol(c)) begin
            do_close = 1'b1;
          end else begin
            e.t0_valid = 1'b1;
            use_n      = 2'd1;
          end
        end
        M_BCOMMENT: begin
          if (c == ChStar && hn && nc == ChSlash) begin
            do_close = 1'b1;
            use_n    = 2'd2;
          end else begin
            e.t0_valid = 1'b1;
            use_n      = 2'd1;
          end
        end
        M_IDENT: begin
          if (c != ChUnder && (is_space(c) || is_punct(c))) begin
            do_close = 1'b1;
          end else begin
            e.t0_valid = 1'b1;
            use_n      = 2'd1;
          end
        end
        M_NUMBER: begin
          if (c == ChLowE || c == ChUpE) begin
            e.t0_valid = 1'b1;
            e.t1_valid = hn;
            use_n      = hn ? 2'd2 : 2'd1;
          end else if (is_space(c) || (is_punct(c) && c != ChDot)) begin
            do_close = 1'b1;
          end else begin
            e.t0_valid = 1'b1;
            use_n      = 2'd1;
          end
        end
        default: begin
          mode_d = M_NONE;
        end
      endcase
      e.t_type  = kind_q;
      e.t0_byte = c;
      e.t1_byte = nc;

      if (do_close) begin
        e.r1_valid    = 1'b1;
        e.r1_type     = kind_q;
        e.r1_start    = start_q;
        e.r1_end.line = line_q;
        e.r1_end.col  = col_q + COL_BITS'(close_adj_i);
        e.r1_end.off  = off_q + OFFSET_BITS'(close_adj_i);
        mode_d        = M_NONE;
        any_d         = 1'b1;
        lle_d         = 1'b0;
      end

      if (use_n == 2'd0) begin
        use_n = 2'd1;
        if (is_eol(c)) begin
          if (any_d && !lle_d) begin
            e.r2_valid = 1'b1;
            e.r2_type  = T_LINEEND;
            e.r2_pos   = here;
            lle_d      = 1'b1;
          end
        end else if (c == ChSlash && hn && nc == ChSlash) begin
          mode_d  = M_LCOMMENT;
          kind_d  = T_COMMENT;
          start_d = here;
          use_n   = 2'd2;
        end else if (c == ChSlash && hn && nc == ChStar) begin
          mode_d  = M_BCOMMENT;
          kind_d  = T_COMMENT;
          start_d = here;
          use_n   = 2'd2;
        end else if (c == ChSquote) begin
          mode_d  = M_CHAR;
          kind_d  = T_CHAR;
          start_d = here;
        end else if (c == ChDquote) begin
          mode_d  = M_STRING;
          kind_d  = T_STRING;
          start_d = here;
        end else if (is_alpha(c) || c == ChUnder) begin
          mode_d     = M_IDENT;
          kind_d     = T_IDENT;
          start_d    = here;
          e.t0_valid = 1'b1;
          e.t_type   = T_IDENT;
        end else if (is_punct(c)) begin
          e.t0_valid = 1'b1;
          e.t_type   = T_SYMBOL;
          e.r2_valid = 1'b1;
          e.r2_type  = T_SYMBOL;
          e.r2_pos   = here;
          any_d      = 1'b1;
          lle_d      = 1'b0;
        end else if (is_digit(c)) begin
          mode_d     = M_NUMBER;
          kind_d     = T_NUMBER;
          start_d    = here;
          e.t0_valid = 1'b1;
          e.t_type   = T_NUMBER;
        end else if (c == ChTab) begin
          tab = 1'b1;
        end
      end

      adv_c = tab ? COL_BITS'(tab_width_i) : COL_BITS'(use_n);
      adv_o = tab ? OFFSET_BITS'(tab_width_i) : OFFSET_BITS'(use_n);
      if (is_eol(c)) begin
        line_d = line_q + 1'b1;
        col_d  = '0;
      end else begin
        col_d = col_q + adv_c;
      end
      off_d = off_q + adv_o;
    end

    if (phase_q == PH_IDLE && accept) begin
      e.last = !eot_i;
      if (held_v_q) begin
        if (use_n == 2'd2) begin
          held_v_d = 1'b0;
        end else begin
          held_d = char_i;
        end
      end else begin
        held_d   = char_i;
        held_v_d = 1'b1;
      end
    end

    if (phase_q == PH_FLUSH && advance) begin
      held_v_d = 1'b0;
    end

    if (phase_q == PH_END && advance) begin
      e.last      = 1'b1;
      e.r1_valid  = (mode_q != M_NONE);
      e.r1_type   = kind_q;
      e.r1_start  = start_q;
      e.r1_end    = here;
      e.r2_valid  = 1'b1;
      e.r2_type   = T_FILEEND;
      e.r2_pos    = '0;
      mode_d      = M_NONE;
      kind_d      = T_COMMENT;
      held_d      = '0;
      held_v_d    = 1'b0;
      line_d      = '0;
      col_d       = '0;
      off_d       = '0;
      start_d     = '0;
      any_d       = 1'b0;
      lle_d       = 1'b0;
    end

    push_o.entry = e;
    push_o.valid = e.r1_valid || e.t0_valid || e.t1_valid || e.r2_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      mode_q   <= M_NONE;
      kind_q   <= T_COMMENT;
      held_q   <= '0;
      held_v_q <= 1'b0;
      line_q   <= '0;
      col_q    <= '0;
      off_q    <= '0;
      start_q  <= '0;
      any_q    <= 1'b0;
      lle_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      kind_q   <= kind_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
      line_q   <= line_d;
      col_q    <= col_d;
      off_q    <= off_d;
      start_q  <= start_d;
      any_q    <= any_d;
      lle_q    <= lle_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/stt_back.sv
`default_nettype none
module stt_back
  import stt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire entry_t    q_data_i,
  input  wire q_stat_t   q_stat_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic           out_kind_o,
  output tok_type_e      out_type_o,
  output logic [7:0]     out_byte_o,
  output pos_t           out_start_o,
  output pos_t           out_end_o,
  output logic           out_last_o
);

  entry_t     cur_q, cur_d;
  logic [3:0] pend_q, pend_d;
  logic       valid_q, valid_d;
  logic       kind_q, kind_d;
  tok_type_e  type_q, type_d;
  logic [7:0] byte_q, byte_d;
  pos_t       spos_q, spos_d;
  pos_t       epos_q, epos_d;
  logic       last_q, last_d;

  always_comb begin
    logic       load_out;
    logic       emit;
    logic [3:0] sel;
    logic [3:0] pend_after;

    load_out   = !valid_q || out_ready_i;
    emit       = load_out && (pend_q != '0);
    sel        = pend_q & (~pend_q + 4'd1);
    pend_after = emit ? (pend_q & ~sel) : pend_q;

    cur_d   = cur_q;
    pend_d  = pend_after;
    valid_d = valid_q;
    kind_d  = kind_q;
    type_d  = type_q;
    byte_d  = byte_q;
    spos_d  = spos_q;
    epos_d  = epos_q;
    last_d  = last_q;

    if (emit) begin
      valid_d = 1'b1;
      last_d  = cur_q.last && (pend_after == '0);
      kind_d  = 1'b1;
      byte_d  = '0;
      spos_d  = '0;
      epos_d  = '0;
      type_d  = cur_q.t_type;
      if (sel[0]) begin
        type_d = cur_q.r1_type;
        spos_d = cur_q.r1_start;
        epos_d = cur_q.r1_end;
      end else if (sel[1]) begin
        kind_d = 1'b0;
        byte_d = cur_q.t0_byte;
      end else if (sel[2]) begin
        kind_d = 1'b0;
        byte_d = cur_q.t1_byte;
      end else begin
        type_d = cur_q.r2_type;
        spos_d = cur_q.r2_pos;
        epos_d = cur_q.r2_pos;
      end
    end else if (load_out) begin
      valid_d = 1'b0;
    end

    pop_o = !q_stat_i.empty && (pend_after == '0);
    if (pop_o) begin
      cur_d  = q_data_i;
      pend_d = {q_data_i.r2_valid, q_data_i.t1_valid, q_data_i.t0_valid, q_data_i.r1_valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    kind_q <= kind_d;
    type_q <= type_d;
    byte_q <= byte_d;
    spos_q <= spos_d;
    epos_q <= epos_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_type_o  = type_q;
  assign out_byte_o  = byte_q;
  assign out_start_o = spos_q;
  assign out_end_o   = epos_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

// File: rtl/source_text_tokenizer_unit.sv
`default_nettype none
// Streaming C-style tokenizer. The front end takes one source byte per cycle
// while the entry queue has room, scans the held lookahead byte and posts one
// queue entry (up to four results) per scan; after a byte with tlast set the
// front end stops taking bytes while it scans the final byte and then posts the
// close and file end entry. The back end drains the queue at one result per
// cycle into the output register while m_axis_tready allows, with the queue
// absorbing bursts at token boundaries.
module source_text_tokenizer_unit
  import stt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // char_byte
  input  wire logic          s_axis_tlast,   // end_of_text
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // token_type, text_byte, start_line, start_col, start_offset,
  // end_line, end_col, end_offset, zero fill
  output logic [135:0]       m_axis_tdata,
  output logic               m_axis_tuser,   // kind
  output logic               m_axis_tlast,   // last_of_run
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0]  tab_q;
  logic        adj_q;
  front_push_t push;
  q_stat_t     q_stat;
  entry_t      q_data;
  logic        pop;
  tok_type_e   out_type;
  pos_t        out_start, out_end;
  logic [7:0]  out_byte;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q <= 4'd4;
      adj_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TAB_WIDTH: tab_q <= pwdata[3:0];
        REG_CLOSE_ADJ: adj_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TAB_WIDTH: prdata = {28'd0, tab_q};
      REG_CLOSE_ADJ: prdata = {31'd0, adj_q};
      default:       prdata = '0;
    endcase
  end

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tab_width_i (tab_q),
    .close_adj_i (adj_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .char_i      (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .q_stat_i    (q_stat),
    .push_o      (push)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_data),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_type_o  (out_type),
    .out_byte_o  (out_byte),
    .out_start_o (out_start),
    .out_end_o   (out_end),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0,
                         out_end.off, out_end.col, out_end.line,
                         out_start.off, out_start.col, out_start.line,
                         out_byte, out_type};

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_stat.full) else $error("entry pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("entry popped from empty queue");

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !q_stat.full) else $error("input ready with full queue");
`endif

endmodule
`default_nettype wire
